@@ rtl/fvnh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fvnh_pkg;

  // Default sizing
  localparam int MAX_OCTAVE_PASSES    = 8;
  localparam int WEIGHT_TABLE_ENTRIES = 256;
  localparam int COORD_FRAC_BITS      = 16;

  // Datapath widths
  localparam int AMP_W  = 41;
  localparam int SUM_W  = 64;
  localparam int MAG_W  = 64;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;
  localparam int WGT_W  = 17;

  // Latency of one octave cell, input register to chain output
  localparam int CELL_LAT = 12;

  // Register reset values
  localparam logic [3:0]  OCTAVES_RST     = 4'd2;
  localparam logic [15:0] PERSISTENCE_RST = 16'd8192;
  localparam logic [31:0] ZOOM_RECIP_RST  = 32'd223696;

  // Amplitude: 1.0 in Q16, capped at 2^40
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
  localparam logic [AMP_W-1:0] AMP_CAP = AMP_W'(64'd1 << 40);

  // Lattice hash constants
  localparam logic [31:0] HASH_ROW  = 32'd57;
  localparam logic [31:0] HASH_MUL  = 32'd60493;
  localparam logic [31:0] HASH_ADD1 = 32'd19990303;
  localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

  // pi in Q30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [IDX_W-1:0] {
    CFG_OCTAVES     = 3'd0,
    CFG_PERSISTENCE = 3'd1,
    CFG_ZOOM_RECIP  = 3'd2,
    CFG_OFFSET_X    = 3'd3,
    CFG_OFFSET_Y    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL,
    ST_RUN,
    ST_FIN
  } state_e;

  // Scaled coordinate magnitudes, shared by all cells
  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             negx;
    logic             negy;
  } coord_t;

  // Data handed from one octave cell to the next
  typedef struct packed {
    logic [AMP_W-1:0]        amp;
    logic signed [SUM_W-1:0] sum;
  } link_t;

  // (1 - cos(th)) / 2 in Q16 for th in Q30, 8-term Taylor series
  function automatic logic [WGT_W-1:0] cos_weight(input longint unsigned th);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          w;
    x2   = (th * th) >> 30;
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    term = ((term * x2) >> 30) / 2;   acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 12;  acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 30;  acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 56;  acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 90;  acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 132; acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 182; acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 240; acc = acc + longint'(term);
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    w = ((64'sd1 << 30) - acc + 64'sd16384) >>> 15;
    if (w > 64'sd65536) w = 64'sd65536;
    return WGT_W'(w);
  endfunction

endpackage

`default_nettype wire

@@ rtl/fvnh_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Four-stage lattice corner hash, value = 2^30 - nn as signed Q2.30
module fvnh_hash (
  input  wire logic        clk_i,
  input  wire logic [31:0] ix_i,
  input  wire logic [31:0] iy_i,
  output logic      [31:0] value_o
);

  logic [31:0] n_d, n0;
  logic [31:0] n_q, n2_q, n3_q;
  logic [31:0] sq_q, inner_q, value_q;
  logic [31:0] nn;

  // mix coordinates
  always_comb begin
    n0  = ix_i + iy_i * fvnh_pkg::HASH_ROW;
    n_d = (n0 << 13) ^ n0;
  end

  assign nn = (n3_q * inner_q + fvnh_pkg::HASH_ADD2) & 32'h7fff_ffff;

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    sq_q    <= n_q * n_q;
    n2_q    <= n_q;
    inner_q <= sq_q * fvnh_pkg::HASH_MUL + fvnh_pkg::HASH_ADD1;
    n3_q    <= n2_q;
    value_q <= fvnh_pkg::ONE_Q30 - nn;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ rtl/fvnh_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One octave pass: lattice split, corner hash, cosine blend, weighted sum
module fvnh_cell #(
  parameter int PASS_IDX             = 0,
  parameter int WEIGHT_TABLE_ENTRIES = fvnh_pkg::WEIGHT_TABLE_ENTRIES,
  parameter int COORD_FRAC_BITS      = fvnh_pkg::COORD_FRAC_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fvnh_pkg::coord_t coord_i,
  input  wire logic [3:0]       octaves_i,
  input  wire logic [15:0]      persistence_i,
  input  wire logic             valid_i,
  input  wire fvnh_pkg::link_t  link_i,
  output logic                  valid_o,
  output fvnh_pkg::link_t       link_o
);

  localparam int Drop = 24 - COORD_FRAC_BITS;
  localparam int IdxW = $clog2(WEIGHT_TABLE_ENTRIES);
  localparam int EntW = $clog2(WEIGHT_TABLE_ENTRIES + 1);
  localparam int ProdW = COORD_FRAC_BITS + EntW;
  localparam logic [5:0] NeedOct = 6'(PASS_IDX + 2);

  // cosine weight table
  logic [fvnh_pkg::WGT_W-1:0] wtab [WEIGHT_TABLE_ENTRIES];

  for (genvar gi = 0; gi < WEIGHT_TABLE_ENTRIES; gi++) begin : g_wtab
    localparam longint unsigned ThA =
      fvnh_pkg::PI_Q30 * 64'(gi) / WEIGHT_TABLE_ENTRIES;
    localparam longint unsigned ThB =
      fvnh_pkg::PI_Q30 * 64'(WEIGHT_TABLE_ENTRIES - gi) / WEIGHT_TABLE_ENTRIES;
    localparam logic [fvnh_pkg::WGT_W-1:0] Wgt = (2 * gi <= WEIGHT_TABLE_ENTRIES)
      ? fvnh_pkg::cos_weight(ThA)
      : fvnh_pkg::WGT_W'(17'd65536 - fvnh_pkg::cos_weight(ThB));
    assign wtab[gi] = Wgt;
  end

  logic [fvnh_pkg::CELL_LAT-1:0] vp_q;
  fvnh_pkg::link_t               in_q;

  // token and input capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else begin
      vp_q <= {vp_q[fvnh_pkg::CELL_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      in_q <= link_i;
    end
  end

  // lattice split for this pass
  logic [127:0]               mwx, mwy;
  logic [63:0]                tx, ty;
  logic [31:0]                ipx, ipy, ix_d, iy_d;
  logic [ProdW-1:0]           prx, pry;
  logic [IdxW-1:0]            idxx, idxy;
  logic [31:0]                ix_q, iy_q;
  logic [fvnh_pkg::WGT_W-1:0] wx_q, wy_q;

  always_comb begin
    mwx  = {64'd0, coord_i.mx} << PASS_IDX;
    mwy  = {64'd0, coord_i.my} << PASS_IDX;
    tx   = mwx[Drop +: 64];
    ty   = mwy[Drop +: 64];
    ipx  = tx[COORD_FRAC_BITS +: 32];
    ipy  = ty[COORD_FRAC_BITS +: 32];
    ix_d = coord_i.negx ? (32'd0 - ipx) : ipx;
    iy_d = coord_i.negy ? (32'd0 - ipy) : ipy;
    prx  = ProdW'(tx[COORD_FRAC_BITS-1:0]) * ProdW'(WEIGHT_TABLE_ENTRIES);
    pry  = ProdW'(ty[COORD_FRAC_BITS-1:0]) * ProdW'(WEIGHT_TABLE_ENTRIES);
    idxx = prx[COORD_FRAC_BITS +: IdxW];
    idxy = pry[COORD_FRAC_BITS +: IdxW];
  end

  always_ff @(posedge clk_i) begin
    ix_q <= ix_d;
    iy_q <= iy_d;
    wx_q <= wtab[idxx];
    wy_q <= wtab[idxy];
  end

  // corner hashes
  logic [31:0] c00, c10, c01, c11;

  fvnh_hash u_h00 (.clk_i, .ix_i(ix_q),        .iy_i(iy_q),        .value_o(c00));
  fvnh_hash u_h10 (.clk_i, .ix_i(ix_q + 32'd1), .iy_i(iy_q),        .value_o(c10));
  fvnh_hash u_h01 (.clk_i, .ix_i(ix_q),        .iy_i(iy_q + 32'd1), .value_o(c01));
  fvnh_hash u_h11 (.clk_i, .ix_i(ix_q + 32'd1), .iy_i(iy_q + 32'd1), .value_o(c11));

  // blend in x, then in y
  logic signed [32:0] dx0, dx1, dy;
  logic signed [50:0] px0_q, px1_q, py_q;
  logic signed [31:0] r0_q, r1_q, v_q;

  always_comb begin
    dx0 = $signed({c10[31], c10}) - $signed({c00[31], c00});
    dx1 = $signed({c11[31], c11}) - $signed({c01[31], c01});
    dy  = $signed({r1_q[31], r1_q}) - $signed({r0_q[31], r0_q});
  end

  always_ff @(posedge clk_i) begin
    px0_q <= dx0 * $signed({1'b0, wx_q});
    px1_q <= dx1 * $signed({1'b0, wx_q});
    r0_q  <= 32'($signed({{19{c00[31]}}, c00}) + (px0_q >>> 16));
    r1_q  <= 32'($signed({{19{c01[31]}}, c01}) + (px1_q >>> 16));
    py_q  <= dy * $signed({1'b0, wy_q});
    v_q   <= 32'($signed({{19{r0_q[31]}}, r0_q}) + (py_q >>> 16));
  end

  // pass term and next amplitude
  logic signed [17:0]            vsh;
  logic signed [59:0]            term_q;
  logic [56:0]                   ap;
  logic [42:0]                   an;
  logic [fvnh_pkg::AMP_W-1:0]    amp_next_q;
  logic                          active;
  fvnh_pkg::link_t               out_q;

  always_comb begin
    vsh    = v_q[31:14];
    ap     = 57'(in_q.amp) * 57'(persistence_i);
    an     = ap[56:14];
    active = {2'b00, octaves_i} >= NeedOct;
  end

  always_ff @(posedge clk_i) begin
    term_q     <= vsh * $signed({1'b0, in_q.amp});
    amp_next_q <= (an > 43'(fvnh_pkg::AMP_CAP)) ? fvnh_pkg::AMP_CAP : an[40:0];
    out_q.amp  <= amp_next_q;
    out_q.sum  <= active ? in_q.sum + 64'(term_q) : in_q.sum;
  end

  assign valid_o = vp_q[fvnh_pkg::CELL_LAT-1];
  assign link_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/fractal_value_noise_height_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Signals                             | Request
// ---------+-----------+-------------------------------------+------------------------
// input    | in        | in_valid_i, in_stall_o, pixel_x/y_i | one pixel coordinate
// output   | out       | out_valid_o, out_stall_i, height_o  | one 8-bit height
// config   | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i    | one register write
//
// One request at a time: an accepted request passes ST_MAG, ST_MUL, the chain
// of octave cells and ST_FIN before its result is loaded into the output register.
// All cells are traversed whatever the octave setting; idle cells pass the sum.
// A new request is taken once the previous result sits in the output register.
// Reset is asynchronous, active low, and restores the register defaults.
// A stalled result holds in the output register; the sequencer waits in ST_FIN behind it.
module fractal_value_noise_height_unit #(
  parameter int MAX_OCTAVE_PASSES    = fvnh_pkg::MAX_OCTAVE_PASSES,
  parameter int WEIGHT_TABLE_ENTRIES = fvnh_pkg::WEIGHT_TABLE_ENTRIES,
  parameter int COORD_FRAC_BITS      = fvnh_pkg::COORD_FRAC_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [15:0]                pixel_x_i,
  input  wire logic [15:0]                pixel_y_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [7:0]                      height_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [fvnh_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [fvnh_pkg::CFG_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [3:0]         octaves_q;
  logic [15:0]        persistence_q;
  logic [31:0]        zoom_q;
  logic signed [31:0] offx_q, offy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q     <= fvnh_pkg::OCTAVES_RST;
      persistence_q <= fvnh_pkg::PERSISTENCE_RST;
      zoom_q        <= fvnh_pkg::ZOOM_RECIP_RST;
      offx_q        <= '0;
      offy_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fvnh_pkg::CFG_OCTAVES:     octaves_q     <= cfg_wdata_i[3:0];
        fvnh_pkg::CFG_PERSISTENCE: persistence_q <= cfg_wdata_i[15:0];
        fvnh_pkg::CFG_ZOOM_RECIP:  zoom_q        <= cfg_wdata_i;
        fvnh_pkg::CFG_OFFSET_X:    offx_q        <= $signed(cfg_wdata_i);
        fvnh_pkg::CFG_OFFSET_Y:    offy_q        <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // sequencer
  fvnh_pkg::state_e state_q, state_d;
  logic             load_out;
  logic             chain_vld [MAX_OCTAVE_PASSES+1];
  logic [MAX_OCTAVE_PASSES:0] chain_vec;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fvnh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      fvnh_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = fvnh_pkg::ST_MAG;
      end
      fvnh_pkg::ST_MAG: state_d = fvnh_pkg::ST_MUL;
      fvnh_pkg::ST_MUL: state_d = fvnh_pkg::ST_RUN;
      fvnh_pkg::ST_RUN: begin
        if (chain_vld[MAX_OCTAVE_PASSES]) state_d = fvnh_pkg::ST_FIN;
      end
      fvnh_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = fvnh_pkg::ST_IDLE;
        end
      end
      default: state_d = fvnh_pkg::ST_IDLE;
    endcase
  end

  // coordinate setup: offset, magnitude, scale by 1/zoom
  logic [15:0]        px_q, py_q;
  logic signed [32:0] cx, cy, ncx, ncy;
  logic [31:0]        magx_q, magy_q;
  logic               negx_q, negy_q;
  fvnh_pkg::coord_t   coord_q;
  logic               start_q;

  always_comb begin
    cx  = $signed({17'd0, px_q}) + $signed({offx_q[31], offx_q});
    cy  = $signed({17'd0, py_q}) + $signed({offy_q[31], offy_q});
    ncx = -cx;
    ncy = -cy;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (state_q == fvnh_pkg::ST_MAG) begin
      magx_q <= cx[32] ? ncx[31:0] : cx[31:0];
      magy_q <= cy[32] ? ncy[31:0] : cy[31:0];
      negx_q <= cx[32];
      negy_q <= cy[32];
    end
    if (state_q == fvnh_pkg::ST_MUL) begin
      coord_q.mx   <= 64'(magx_q) * 64'(zoom_q);
      coord_q.my   <= 64'(magy_q) * 64'(zoom_q);
      coord_q.negx <= negx_q;
      coord_q.negy <= negy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= (state_q == fvnh_pkg::ST_MUL);
    end
  end

  // chain of octave cells
  fvnh_pkg::link_t links [MAX_OCTAVE_PASSES+1];

  assign chain_vld[0]    = start_q;
  assign links[0].amp    = fvnh_pkg::AMP_ONE;
  assign links[0].sum    = '0;

  for (genvar gc = 0; gc < MAX_OCTAVE_PASSES; gc++) begin : g_cell
    fvnh_cell #(
      .PASS_IDX             (gc),
      .WEIGHT_TABLE_ENTRIES (WEIGHT_TABLE_ENTRIES),
      .COORD_FRAC_BITS      (COORD_FRAC_BITS)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .coord_i       (coord_q),
      .octaves_i     (octaves_q),
      .persistence_i (persistence_q),
      .valid_i       (chain_vld[gc]),
      .link_i        (links[gc]),
      .valid_o       (chain_vld[gc+1]),
      .link_o        (links[gc+1])
    );
  end

  for (genvar gv = 0; gv <= MAX_OCTAVE_PASSES; gv++) begin : g_vec
    assign chain_vec[gv] = chain_vld[gv];
  end

  // final sum to height
  logic signed [fvnh_pkg::SUM_W-1:0] sum_q;
  logic signed [64:0]                total;
  logic [7:0]                        height_d, height_q;

  always_ff @(posedge clk_i) begin
    if (chain_vld[MAX_OCTAVE_PASSES]) begin
      sum_q <= links[MAX_OCTAVE_PASSES].sum;
    end
  end

  always_comb begin
    total = $signed({sum_q[63], sum_q}) + 65'sd4294967296;
    if (total[64] || (total == 65'sd0)) begin
      height_d = 8'd0;
    end else if (total[63:33] != 31'd0) begin
      height_d = 8'd255;
    end else begin
      height_d = total[32:25];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      height_q <= height_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign height_o    = height_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == fvnh_pkg::ST_MAG)
    else $error("accepted request did not start setup");
  a_chain_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[MAX_OCTAVE_PASSES] |-> state_q == fvnh_pkg::ST_RUN)
    else $error("chain result outside run state");
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vec))
    else $error("more than one token in the cell chain");
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fvnh_pkg::ST_FIN && !out_valid_q |=> out_valid_o)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 3000000;
  localparam int DRAIN = 120;

  typedef struct {
    bit [15:0] px;
    bit [15:0] py;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] pixel_x_i = '0;
  logic [15:0] pixel_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] height_o;
  logic cfg_we_i = 1'b0;
  fvnh_pkg::cfg_idx_e cfg_idx_i = fvnh_pkg::CFG_OCTAVES;
  logic [fvnh_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  // Shadow copy of the register file
  bit [3:0] octaves_r = fvnh_pkg::OCTAVES_RST;
  bit [15:0] persist_r = fvnh_pkg::PERSISTENCE_RST;
  bit [31:0] zoom_r = fvnh_pkg::ZOOM_RECIP_RST;
  logic signed [31:0] off_x_r = '0;
  logic signed [31:0] off_y_r = '0;

  longint cos_tab[fvnh_pkg::WEIGHT_TABLE_ENTRIES+1];
  pixel_t pixel_q[$];
  bit [7:0] height_q[$];
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int fail_cnt = 0;
  int cycles = 0;

  fractal_value_noise_height_unit dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Cosine blend weights, Q16
  function automatic void build_cos_tab();
    longint unsigned th, x2, term;
    longint acc, w;
    for (int i = 0; i <= fvnh_pkg::WEIGHT_TABLE_ENTRIES; i++) begin
      if (2 * i <= fvnh_pkg::WEIGHT_TABLE_ENTRIES) begin
        th = fvnh_pkg::PI_Q30 * i / fvnh_pkg::WEIGHT_TABLE_ENTRIES;
        x2 = (th * th) >> 30;
        term = 64'd1 << 30;
        acc = 64'sd1 << 30;
        for (int k = 1; k <= 8; k++) begin
          term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
          if (k % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        w = ((64'sd1 << 30) - acc + 16384) >>> 15;
        if (w > 65536) w = 65536;
        cos_tab[i] = w;
      end else begin
        cos_tab[i] = 65536 - cos_tab[fvnh_pkg::WEIGHT_TABLE_ENTRIES - i];
      end
    end
  endfunction

  // Lattice corner hash, Q30 signed
  function automatic longint lattice_val(bit [31:0] ix, bit [31:0] iy);
    bit [31:0] n, nn;
    n = ix + iy * 32'd57;
    n = (n << 13) ^ n;
    nn = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
    return (64'sd1 << 30) - longint'({32'b0, nn});
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> 16);
  endfunction

  // Lattice integer and weight of one axis for one octave pass
  function automatic void split_axis(longint c, int a, output bit [31:0] ip,
                                     output longint w);
    longint unsigned m, t;
    bit [31:0] ip0;
    int drop;
    drop = 24 - fvnh_pkg::COORD_FRAC_BITS;
    m = (c < 0) ? longint'(-c) : c;
    m = m * {32'b0, zoom_r};
    if (a <= drop) t = m >> (drop - a);
    else t = m << (a - drop);
    ip0 = t[fvnh_pkg::COORD_FRAC_BITS +: 32];
    ip = (c < 0) ? 32'd0 - ip0 : ip0;
    w = cos_tab[((t & ((64'd1 << fvnh_pkg::COORD_FRAC_BITS) - 1)) *
                 fvnh_pkg::WEIGHT_TABLE_ENTRIES) >> fvnh_pkg::COORD_FRAC_BITS];
  endfunction

  function automatic bit [7:0] noise_height(bit [15:0] px, bit [15:0] py);
    longint cx, cy, pxl, pyl, ox, oy, wx, wy, r0, r1, v, acc, total;
    longint unsigned amp;
    bit [31:0] ix, iy;
    int passes;
    pxl = px;
    pyl = py;
    ox = off_x_r;
    oy = off_y_r;
    cx = pxl + ox;
    cy = pyl + oy;
    passes = (octaves_r >= 2) ? octaves_r - 1 : 0;
    if (passes > fvnh_pkg::MAX_OCTAVE_PASSES) passes = fvnh_pkg::MAX_OCTAVE_PASSES;
    amp = 65536;
    acc = 0;
    for (int a = 0; a < passes; a++) begin
      split_axis(cx, a, ix, wx);
      split_axis(cy, a, iy, wy);
      r0 = mix(lattice_val(ix, iy), lattice_val(ix + 1, iy), wx);
      r1 = mix(lattice_val(ix, iy + 1), lattice_val(ix + 1, iy + 1), wx);
      v = mix(r0, r1, wy);
      acc = acc + (v >>> 14) * longint'(amp);
      amp = (amp >> 14) * persist_r + (((amp & 64'h3fff) * persist_r) >> 14);
      if (amp > (64'd1 << 40)) amp = 64'd1 << 40;
    end
    total = acc + (64'sd1 << 32);
    if (total <= 0) return 8'd0;
    if ((total >>> 25) > 255) return 8'd255;
    return total[32:25];
  endfunction

  // Request driver: the head of pixel_q is the request on the port
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      height_q.push_back(noise_height(pixel_x_i, pixel_y_i));
      void'(pixel_q.pop_front());
    end
    if (!in_valid_i || !in_stall_o) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid_i <= 1'b1;
        pixel_x_i <= pixel_q[0].px;
        pixel_y_i <= pixel_q[0].py;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and stall generation
  always @(posedge clk_i) begin
    bit [7:0] want;
    if (out_valid_o && !out_stall_i) begin
      if (height_q.size() == 0) begin
        $error("unexpected height %0d", height_o);
        fail_cnt++;
      end else begin
        want = height_q.pop_front();
        if (height_o !== want) begin
          $error("height: expected %0d, got %0d", want, height_o);
          fail_cnt++;
        end
      end
    end
    if (hold_req) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    out_stall_i <= hold_req || hold_cnt > 1 || $urandom_range(99) < recv_stall;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(fvnh_pkg::cfg_idx_e idx, bit [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      fvnh_pkg::CFG_OCTAVES:     octaves_r = data[3:0];
      fvnh_pkg::CFG_PERSISTENCE: persist_r = data[15:0];
      fvnh_pkg::CFG_ZOOM_RECIP:  zoom_r = data;
      fvnh_pkg::CFG_OFFSET_X:    off_x_r = data;
      fvnh_pkg::CFG_OFFSET_Y:    off_y_r = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(bit [3:0] oct, bit [15:0] pers, bit [31:0] zr,
                         bit [31:0] ox, bit [31:0] oy);
    reg_write(fvnh_pkg::CFG_OCTAVES, 32'(oct));
    reg_write(fvnh_pkg::CFG_PERSISTENCE, 32'(pers));
    reg_write(fvnh_pkg::CFG_ZOOM_RECIP, zr);
    reg_write(fvnh_pkg::CFG_OFFSET_X, ox);
    reg_write(fvnh_pkg::CFG_OFFSET_Y, oy);
  endtask

  task automatic add_pixel(bit [15:0] px, bit [15:0] py);
    pixel_t p;
    p.px = px;
    p.py = py;
    pixel_q.push_back(p);
  endtask

  // Every request is answered, so idle means both queues drained
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || height_q.size() != 0);
  endtask

  function automatic bit [31:0] pick_offset();
    case ($urandom_range(3))
      0: return 32'h8000_0000 + $urandom_range(70000);
      1: return 32'h7fff_ffff - $urandom_range(70000);
      2: return $urandom;
      default: return 32'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  initial begin
    bit [31:0] zr;
    build_cos_tab();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, coordinate extremes
    @(negedge clk_i);
    add_pixel(16'h0000, 16'h0000);
    add_pixel(16'hffff, 16'hffff);
    add_pixel(16'h0000, 16'hffff);
    add_pixel(16'hffff, 16'h0000);
    add_pixel(16'h5555, 16'haaaa);
    wait_idle();
    // No passes: octaves zero and one
    set_all(4'd0, 16'd8192, 32'd223696, 32'd0, 32'd0);
    add_pixel(16'd123, 16'd456);
    wait_idle();
    reg_write(fvnh_pkg::CFG_OCTAVES, 32'd1);
    add_pixel(16'hffff, 16'd7);
    wait_idle();
    // Octaves above range, huge amplitude, huge coordinates
    set_all(4'd15, 16'hffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_pixel(16'hffff, 16'hffff);
    add_pixel(16'd0, 16'd1);
    add_pixel(16'h8000, 16'h00ff);
    wait_idle();
    // Most negative offsets, negative coordinates
    set_all(4'd9, 16'd0, 32'h0100_0000, 32'h8000_0000, 32'h8000_0000);
    add_pixel(16'd0, 16'd0);
    add_pixel(16'hffff, 16'hffff);
    wait_idle();
    set_all(4'd5, 16'd16384, 32'd1 << 20, 32'hffff_ff00, 32'hffff_fff0);
    add_pixel(16'd3, 16'd200);
    add_pixel(16'd255, 16'd17);
    wait_idle();
    // Zero zoom reciprocal and the smallest nonzero one
    set_all(4'd9, 16'd32768, 32'd0, 32'd1000, 32'hffff_0000);
    add_pixel(16'd9, 16'd99);
    wait_idle();
    reg_write(fvnh_pkg::CFG_ZOOM_RECIP, 32'd1);
    add_pixel(16'hffff, 16'd0);
    wait_idle();

    // Random phases, rotating through the idling patterns
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      if ($urandom_range(1)) zr = (32'd1 << 24) / $urandom_range(1, 300);
      else zr = $urandom;
      set_all(4'($urandom_range(15)), 16'($urandom), zr, pick_offset(), pick_offset());
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(3) == 0) begin
          add_pixel(16'($urandom_range(255)), 16'($urandom_range(255)));
        end else begin
          add_pixel(16'($urandom), 16'($urandom));
        end
      end
      // Long receiver hold-off while requests keep coming
      if (ph == 3) begin
        @(negedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
        hold_req = 1'b0;
      end
      wait_idle();
    end

    repeat (DRAIN) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
